// File: src/priority_scheduler_with_aging_unit_defines.svh
// Assertion macros shared by the scheduler checker.
`ifndef PRIORITY_SCHEDULER_WITH_AGING_UNIT_DEFINES_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_UNIT_DEFINES_SVH

// Assert that a property holds on every clock edge outside reset.
`define PSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert a property that must also hold while reset is applied.
`define PSA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/psa_pkg.sv
// Package: types, constants and helpers for the priority scheduler.
`default_nettype none
package psa_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] TIME_SLICE_RESET  = 8'd2;
   localparam logic [7:0] AGING_LIMIT_RESET = 8'd5;

   localparam logic CSR_TIME_SLICE  = 1'b0;
   localparam logic CSR_AGING_LIMIT = 1'b1;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_ROUND  = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_RAN      = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [7:0]  task_id;
      logic [3:0]  priority_req;
      logic [15:0] work;
      logic [15:0] arrival;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  run_id;
      logic [3:0]  run_priority;
      logic [7:0]  exec_amount;
      logic [15:0] remaining;
      logic        finished;
      logic [31:0] time_now;
      logic [31:0] lifetime;
   } rsp_word_type;

   // One queued task as it travels along the chain.
   typedef struct packed {
      logic        valid;
      logic [7:0]  id;
      logic [3:0]  prio;
      logic [15:0] remaining;
      logic [15:0] arrival;
      logic [7:0]  wait_cnt;
      logic [15:0] order;
   } task_type;

   // Commands broadcast by the sequencer to every cell.
   typedef struct packed {
      logic       rotate;     // shift the ring one place
      logic       age;        // age the cell leaving the ring end
      logic       write_new;  // load the free cell leaving the end
      logic       update;     // rewrite the chosen cell leaving the end
      logic       retire;     // drop the chosen cell leaving the end
      logic [7:0] aging_limit;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_AGE,
      S_SEARCH,
      S_APPLY,
      S_RESPOND
   } state_type;

   // True when task a must run before task b; now is the order counter.
   function automatic logic ahead(task_type a, task_type b, logic [15:0] now);
      logic [15:0] age_a;
      logic [15:0] age_b;
      age_a = now - a.order;
      age_b = now - b.order;
      if (a.prio != b.prio) return a.prio < b.prio;
      if (a.arrival != b.arrival) return a.arrival < b.arrival;
      return age_a > age_b;
   endfunction

endpackage
`default_nettype wire

// File: src/psa_cell.sv
// One queue cell: holds a task, passes it along the ring on rotate.
`default_nettype none
module psa_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  psa_pkg::cell_ctl_type ctl,
   input  psa_pkg::task_type     prev_task,
   output psa_pkg::task_type     task_out
);
   psa_pkg::task_type task_ff;
   psa_pkg::task_type task_in;

   always_comb begin
      task_in = task_ff;
      if (ctl.rotate) begin
         task_in = prev_task;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_ff.valid <= 1'b0;
      end else begin
         task_ff.valid <= task_in.valid;
      end
      task_ff.id        <= task_in.id;
      task_ff.prio      <= task_in.prio;
      task_ff.remaining <= task_in.remaining;
      task_ff.arrival   <= task_in.arrival;
      task_ff.wait_cnt  <= task_in.wait_cnt;
      task_ff.order     <= task_in.order;
   end

   assign task_out = task_ff;
endmodule
`default_nettype wire

// File: src/psa_seq.sv
// Sequencer: walks the ring of cells for insert, aging, search and update.
`default_nettype none
module psa_seq (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  psa_pkg::req_word_type req_word,
   input  wire [7:0]             time_slice,
   input  wire [7:0]             aging_limit,
   input  psa_pkg::task_type     tail_task,
   output psa_pkg::task_type     feed_task,
   output psa_pkg::cell_ctl_type ctl,
   output logic                  rsp_strobe,
   output psa_pkg::rsp_word_type rsp_word
);
   localparam logic [psa_pkg::CNT_W-1:0] LAST = psa_pkg::CNT_W'(psa_pkg::QUEUE_DEPTH - 1);

   psa_pkg::state_type state_ff, state_in;
   logic [psa_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   psa_pkg::req_word_type req_ff, req_in;
   logic [15:0] order_ff, order_in;
   logic [31:0] time_ff, time_in;
   psa_pkg::task_type best_ff, best_in;
   logic [psa_pkg::SLOT_W-1:0] best_pos_ff, best_pos_in;
   logic done_ff, done_in;
   psa_pkg::rsp_word_type rsp_ff, rsp_in;
   logic strobe_ff, strobe_in;

   psa_pkg::task_type aged;
   logic [7:0] wait_inc;
   logic [15:0] exec16;
   logic [15:0] left;
   logic [31:0] time_after;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= psa_pkg::S_IDLE;
         order_ff  <= '0;
         time_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         order_ff  <= order_in;
         time_ff   <= time_in;
         strobe_ff <= strobe_in;
      end
      cnt_ff      <= cnt_in;
      req_ff      <= req_in;
      best_ff     <= best_in;
      best_pos_ff <= best_pos_in;
      done_ff     <= done_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      wait_inc = (tail_task.wait_cnt == 8'hFF) ? 8'hFF : tail_task.wait_cnt + 8'd1;
      aged = tail_task;
      aged.wait_cnt = wait_inc;
      if (wait_inc >= aging_limit && tail_task.prio != 4'd0) begin
         aged.prio = tail_task.prio - 4'd1;
         aged.wait_cnt = '0;
      end
      exec16 = ({8'd0, time_slice} < best_ff.remaining) ? {8'd0, time_slice}
                                                        : best_ff.remaining;
      left = best_ff.remaining - exec16;
      time_after = time_ff + {16'd0, exec16};
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      req_in      = req_ff;
      order_in    = order_ff;
      time_in     = time_ff;
      best_in     = best_ff;
      best_pos_in = best_pos_ff;
      done_in     = done_ff;
      rsp_in      = rsp_ff;
      strobe_in   = 1'b0;
      feed_task   = tail_task;
      ctl         = '0;
      ctl.aging_limit = aging_limit;
      busy        = (state_ff != psa_pkg::S_IDLE);

      unique case (state_ff)
         psa_pkg::S_IDLE: begin
            if (start) begin
               req_in  = req_word;
               cnt_in  = '0;
               done_in = 1'b0;
               best_in = '0;
               state_in = (req_word.mode == psa_pkg::MODE_INSERT) ? psa_pkg::S_INSERT
                                                                  : psa_pkg::S_AGE;
            end
         end
         // Rotate once round; cell leaving the tail at pass k is slot k.
         psa_pkg::S_INSERT: begin
            ctl.rotate = 1'b1;
            if (!tail_task.valid && !done_ff) begin
               done_in = 1'b1;
               feed_task.valid     = 1'b1;
               feed_task.id        = req_ff.task_id;
               feed_task.prio      = req_ff.priority_req;
               feed_task.remaining = req_ff.work;
               feed_task.arrival   = req_ff.arrival;
               feed_task.wait_cnt  = '0;
               feed_task.order     = order_ff;
               order_in = order_ff + 16'd1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               rsp_in = '0;
               rsp_in.status = (done_in) ? psa_pkg::ST_INSERTED : psa_pkg::ST_FULL;
               rsp_in.time_now = time_ff;
               state_in = psa_pkg::S_RESPOND;
            end
         end
         // Age and search in the same pass: compare aged values.
         psa_pkg::S_AGE: begin
            ctl.rotate = 1'b1;
            ctl.age = 1'b1;
            if (tail_task.valid) begin
               feed_task = aged;
               if (!best_ff.valid || psa_pkg::ahead(aged, best_ff, order_ff)) begin
                  best_in = aged;
                  best_pos_in = cnt_ff[psa_pkg::SLOT_W-1:0];
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               cnt_in = '0;
               state_in = psa_pkg::S_SEARCH;
            end
         end
         psa_pkg::S_SEARCH: begin
            rsp_in = '0;
            rsp_in.time_now = time_ff;
            if (!best_ff.valid) begin
               rsp_in.status = psa_pkg::ST_EMPTY;
               state_in = psa_pkg::S_RESPOND;
            end else begin
               time_in = time_after;
               rsp_in.status       = psa_pkg::ST_RAN;
               rsp_in.run_id       = best_ff.id;
               rsp_in.run_priority = best_ff.prio;
               rsp_in.exec_amount  = exec16[7:0];
               rsp_in.remaining    = left;
               rsp_in.finished     = (left == 16'd0);
               rsp_in.time_now     = time_after;
               rsp_in.lifetime     = (left == 16'd0) ?
                                     time_after - {16'd0, best_ff.arrival} : 32'd0;
               state_in = psa_pkg::S_APPLY;
            end
         end
         // Second pass: rewrite or drop the chosen slot.
         psa_pkg::S_APPLY: begin
            ctl.rotate = 1'b1;
            if (cnt_ff[psa_pkg::SLOT_W-1:0] == best_pos_ff) begin
               ctl.update = 1'b1;
               if (rsp_ff.finished) begin
                  ctl.retire = 1'b1;
                  feed_task.valid = 1'b0;
               end else begin
                  feed_task.remaining = rsp_ff.remaining;
                  feed_task.wait_cnt  = '0;
                  feed_task.order     = order_ff;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               if (!rsp_ff.finished) begin
                  order_in = order_ff + 16'd1;
               end
               state_in = psa_pkg::S_RESPOND;
            end
         end
         psa_pkg::S_RESPOND: begin
            strobe_in = 1'b1;
            state_in = psa_pkg::S_IDLE;
         end
         default: state_in = psa_pkg::S_IDLE;
      endcase
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;
endmodule
`default_nettype wire

// File: src/priority_scheduler_with_aging_unit.sv
// Top level: priority scheduler with aging, a ring of task cells and a sequencer.
//
//   channel  | ports                         | handshake
//   request  | start, busy, req_word         | taken when start and not busy
//   response | rsp_strobe, rsp_word          | one-cycle strobe, no back-pressure
//   config   | csr_we, csr_index, csr_wdata  | written on any edge with csr_we
//
// An insert makes one pass of the ring before its response word is issued.
// A round makes two passes: one to age and pick, one to write back;
// a round on an empty queue skips the write-back pass.
// The ring rotates one cell a cycle, so the pass length is set by the queue depth.
// Synchronous reset empties every cell and clears time and order counters.
// The receiver cannot stall; busy falls as the strobe rises, so the next word can be
// taken at the edge that ends the strobe cycle.
`default_nettype none
module priority_scheduler_with_aging_unit (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  psa_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output psa_pkg::rsp_word_type rsp_word,
   input  wire                   csr_we,
   input  wire                   csr_index,
   input  wire [7:0]             csr_wdata
);
   logic [7:0] time_slice_ff, aging_limit_ff;
   psa_pkg::cell_ctl_type ctl;
   psa_pkg::task_type feed_task;
   psa_pkg::task_type chain [psa_pkg::QUEUE_DEPTH];
   logic seq_busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_slice_ff  <= psa_pkg::TIME_SLICE_RESET;
         aging_limit_ff <= psa_pkg::AGING_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            psa_pkg::CSR_TIME_SLICE:  time_slice_ff  <= csr_wdata;
            psa_pkg::CSR_AGING_LIMIT: aging_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Ring of cells: cell 0 takes the sequencer's feed, the last cell is the tail.
   for (genvar i = 0; i < psa_pkg::QUEUE_DEPTH; i++) begin : g_cell
      psa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .prev_task ((i == 0) ? feed_task : chain[(i == 0) ? 0 : i - 1]),
         .task_out  (chain[i])
      );
   end

   psa_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (seq_busy),
      .req_word    (req_word),
      .time_slice  (time_slice_ff),
      .aging_limit (aging_limit_ff),
      .tail_task   (chain[psa_pkg::QUEUE_DEPTH-1]),
      .feed_task   (feed_task),
      .ctl         (ctl),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word)
   );

   assign busy = seq_busy;
endmodule
`default_nettype wire

// File: src/psa_checker.sv
// Port-level checker for the priority scheduler, bound to the top level.
`default_nettype none
`include "priority_scheduler_with_aging_unit_defines.svh"
module psa_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   start,
   input wire                   busy,
   input wire                   rsp_strobe,
   input psa_pkg::rsp_word_type rsp_word
);
   `PSA_ASSERT(a_start_busy, clock, reset, start && !busy |=> busy, "no busy after start")
   `PSA_ASSERT(a_strobe_idle, clock, reset, rsp_strobe |-> !busy, "strobe while busy")
   `PSA_ASSERT(a_strobe_end, clock, reset, rsp_strobe |=> !rsp_strobe, "strobe not single")
   `PSA_ASSERT(a_fields, clock, reset, rsp_strobe && rsp_word.status != psa_pkg::ST_RAN |-> rsp_word.run_id == 8'd0 && rsp_word.lifetime == 32'd0, "stale fields")
   `PSA_ASSERT_ALWAYS(a_reset, clock, reset |=> !busy && !rsp_strobe, "not idle after reset")
endmodule

bind priority_scheduler_with_aging_unit psa_checker u_psa_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
`default_nettype wire
